/* rtl/dtcm_pkg.sv */
package dtcm_pkg;

  localparam int unsigned MaxCellsDef = 256;
  localparam int unsigned DepthW      = 32;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned CoordsW     = 3 * CoordW;
  localparam int unsigned TolW        = 31;
  localparam int unsigned DistW       = 33;
  localparam int unsigned GridW       = 17;
  localparam int unsigned MatchIdxW   = 8;

  // 100000 m in Q16.16
  localparam logic [DistW-1:0] NoMatchDist = 33'd6553600000;
  localparam logic [TolW-1:0]  DistSat     = 31'h7FFF_FFFF;
  localparam logic [TolW-1:0]  TolReset    = 31'd65536;

  typedef struct packed {
    logic                     valid;
    logic                     hit;
    logic signed [DepthW-1:0] qdepth;
    logic [DistW-1:0]         best_dist;
    logic [CoordsW-1:0]       best_coords;
    logic signed [DepthW-1:0] prev_depth;
    logic [CoordsW-1:0]       prev_coords;
  } token_t;

  typedef struct packed {
    logic                     we;
    logic signed [DepthW-1:0] depth;
    logic [CoordsW-1:0]       coords;
  } wr_t;

endpackage

/* rtl/dtcm_cell.sv */
module dtcm_cell #(
  parameter int unsigned MaxCells = dtcm_pkg::MaxCellsDef,
  parameter int unsigned Index    = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dtcm_pkg::wr_t                      wr_i,
  input  logic [$clog2(MaxCells)-1:0]        wr_idx_i,
  input  logic                               mono_i,
  input  logic [$clog2(MaxCells)-1:0]        start_i,
  input  logic [$clog2(MaxCells+1)-1:0]      count_i,
  input  dtcm_pkg::token_t                   tok_i,
  input  logic [$clog2(MaxCells)-1:0]        idx_i,
  output dtcm_pkg::token_t                   tok_o,
  output logic [$clog2(MaxCells)-1:0]        idx_o
);
  import dtcm_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxCells);
  localparam int unsigned CntW = $clog2(MaxCells + 1);
  localparam logic [IdxW-1:0] MyIdx   = IdxW'(Index);
  localparam logic [IdxW-1:0] PairIdx = IdxW'((Index > 0) ? Index - 1 : 0);
  localparam logic [CntW-1:0] MyCnt   = CntW'(Index);

  logic signed [DepthW-1:0] depth_q;
  logic [CoordsW-1:0]       coords_q;
  token_t                   tok_d, tok_q;
  logic                     valid_q;
  logic [IdxW-1:0]          idx_d, idx_q;
  logic signed [DistW-1:0]  diff;
  logic [DistW-1:0]         mag;
  logic [TolW-1:0]          sat_dist;
  logic                     near_ok, pair_ok, brk;

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_idx_i == MyIdx)) begin
      depth_q  <= wr_i.depth;
      coords_q <= wr_i.coords;
    end
  end

  always_comb begin
    diff = {tok_i.qdepth[DepthW-1], tok_i.qdepth} - {depth_q[DepthW-1], depth_q};
    mag  = diff[DistW-1] ? DistW'(-diff) : DistW'(diff);
    sat_dist = (mag > {2'b00, DistSat}) ? DistSat : mag[TolW-1:0];

    near_ok = (MyIdx >= start_i) && (MyCnt < count_i);
    pair_ok = (Index > 0) && (MyIdx > start_i) && (MyCnt < count_i) && !tok_i.hit;
    brk = ((depth_q > tok_i.qdepth) && (tok_i.qdepth > tok_i.prev_depth)) ||
          ((depth_q < tok_i.qdepth) && (tok_i.qdepth < tok_i.prev_depth));

    tok_d             = tok_i;
    idx_d             = idx_i;
    tok_d.prev_depth  = depth_q;
    tok_d.prev_coords = coords_q;
    if (mono_i) begin
      if (near_ok && ({2'b00, sat_dist} < tok_i.best_dist)) begin
        tok_d.best_dist   = {2'b00, sat_dist};
        tok_d.best_coords = coords_q;
        idx_d             = MyIdx;
      end
    end else begin
      if (pair_ok && brk) begin
        tok_d.hit         = 1'b1;
        tok_d.best_dist   = '0;
        tok_d.best_coords = tok_i.prev_coords;
        idx_d             = PairIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    idx_q <= idx_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

  assign idx_o = idx_q;

endmodule

/* rtl/depth_to_cell_nearest_mapper_top.sv */
// load beat: taken while idle, no result beat
// query beat: the query token is registered, then walks the row of cells one cell per
// cycle; the result then passes the StScan and StHold states into the output register
// input is not accepted while a query is in the row or its result awaits the output register
// reset clears the cell count, search start and step sign, sets the monotone flag
// and loads the tolerance with 1.0 m; cell contents are undefined until loaded
module depth_to_cell_nearest_mapper_top #(
  parameter int unsigned MaxCells = dtcm_pkg::MaxCellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // depth, cell_i, cell_j, cell_k
  input  logic [1:0]  s_axis_tuser,   // func, start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // grid_i, grid_j, grid_k, matched_index, zero pad
  output logic [1:0]  m_axis_tuser    // found, monotone_well
);
  import dtcm_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxCells);
  localparam int unsigned CntW = $clog2(MaxCells + 1);
  localparam logic [1:0] SignNone = 2'd0;
  localparam logic [1:0] SignPos  = 2'd1;
  localparam logic [1:0] SignNeg  = 2'd2;
  localparam logic       FuncLoad = 1'b0;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StHold
  } state_e;

  state_e                   state_q;
  logic [TolW-1:0]          tol_q;
  logic [CntW-1:0]          cnt_q;
  logic [IdxW-1:0]          start_q;
  logic                     mono_q;
  logic [1:0]               first_sign_q;
  logic signed [DepthW-1:0] prev_depth_q;
  token_t                   inj_q;
  logic                     hold_found_q;
  logic [CoordsW-1:0]       hold_coords_q;
  logic [IdxW-1:0]          hold_idx_q;
  logic                     out_valid_q;
  logic [63:0]              out_data_q;
  logic [1:0]               out_user_q;

  token_t                   tok [0:MaxCells];
  logic [IdxW-1:0]          tidx [0:MaxCells];
  wr_t                      wr;
  logic [IdxW-1:0]          wr_idx;

  logic                     accept, func, start;
  logic signed [DepthW-1:0] in_depth;
  logic [CoordsW-1:0]       in_coords;
  logic [CntW-1:0]          cnt_eff;
  logic                     full;
  logic [1:0]               step_sign;
  logic                     res_found;
  logic [IdxW+MatchIdxW-1:0] idx_ext;
  logic [GridW-1:0]         gi, gj, gk;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tuser[0];
  assign start         = s_axis_tuser[1];
  assign in_depth      = s_axis_tdata[31:0];
  assign in_coords     = {s_axis_tdata[79:64], s_axis_tdata[63:48], s_axis_tdata[47:32]};

  assign cnt_eff   = start ? '0 : cnt_q;
  assign full      = (cnt_eff >= CntW'(MaxCells));
  assign wr_idx    = cnt_eff[IdxW-1:0];
  assign wr.we     = accept && (func == FuncLoad) && !full;
  assign wr.depth  = in_depth;
  assign wr.coords = in_coords;

  assign step_sign = (in_depth > prev_depth_q) ? SignPos :
                     (in_depth < prev_depth_q) ? SignNeg : SignNone;

  assign tok[0]  = inj_q;
  assign tidx[0] = '0;

  for (genvar g = 0; g < MaxCells; g++) begin : g_cell
    dtcm_cell #(
      .MaxCells(MaxCells),
      .Index   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .wr_idx_i(wr_idx),
      .mono_i  (mono_q),
      .start_i (start_q),
      .count_i (cnt_q),
      .tok_i   (tok[g]),
      .idx_i   (tidx[g]),
      .tok_o   (tok[g+1]),
      .idx_o   (tidx[g+1])
    );
  end

  assign res_found = tok[MaxCells].best_dist < {2'b00, tol_q};
  assign idx_ext   = {{MatchIdxW{1'b0}}, hold_idx_q};
  assign gi = hold_found_q ? {1'b0, hold_coords_q[15:0]}  : '1;
  assign gj = hold_found_q ? {1'b0, hold_coords_q[31:16]} : '1;
  assign gk = hold_found_q ? {1'b0, hold_coords_q[47:32]} : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      tol_q         <= TolReset;
      cnt_q         <= '0;
      start_q       <= '0;
      mono_q        <= 1'b1;
      first_sign_q  <= SignNone;
      prev_depth_q  <= '0;
      inj_q         <= '0;
      hold_found_q  <= 1'b0;
      hold_coords_q <= '0;
      hold_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_user_q    <= '0;
    end else begin
      inj_q.valid <= accept && (func != FuncLoad);
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready && (state_q != StHold)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (func == FuncLoad) begin
              if (start) begin
                start_q      <= '0;
                mono_q       <= 1'b1;
                first_sign_q <= SignNone;
              end
              if (!full) begin
                if (cnt_eff == CntW'(1)) begin
                  first_sign_q <= step_sign;
                end else if (cnt_eff > CntW'(1) && step_sign != SignNone &&
                             (start ? SignNone : first_sign_q) != SignNone &&
                             step_sign != first_sign_q) begin
                  mono_q <= 1'b0;
                end
                prev_depth_q <= in_depth;
                cnt_q        <= cnt_eff + CntW'(1);
              end
            end else begin
              if (start) begin
                start_q <= '0;
              end
              inj_q.hit         <= 1'b0;
              inj_q.qdepth      <= in_depth;
              inj_q.best_dist   <= NoMatchDist;
              inj_q.best_coords <= '0;
              inj_q.prev_depth  <= '0;
              inj_q.prev_coords <= '0;
              state_q           <= StScan;
            end
          end
        end
        StScan: begin
          if (tok[MaxCells].valid) begin
            hold_found_q  <= res_found;
            hold_coords_q <= tok[MaxCells].best_coords;
            hold_idx_q    <= res_found ? tidx[MaxCells] : '0;
            if (res_found) begin
              start_q <= tidx[MaxCells];
            end
            state_q <= StHold;
          end
        end
        StHold: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {5'b0, idx_ext[MatchIdxW-1:0], gk, gj, gi};
            out_user_q  <= {mono_q, hold_found_q};
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
